FILE: rtl/rwwm_pkg.sv
package rwwm_pkg;

  localparam int unsigned WINDOW_MAX  = 1024;
  localparam int unsigned SAMPLE_BITS = 32;

  localparam int unsigned PTR_W  = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W  = PTR_W + 1;
  localparam int unsigned SUM_W  = 52;
  localparam int unsigned WSUM_W = 42;
  localparam int unsigned PROD_W = SAMPLE_BITS + CNT_W + 1;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned LEN_W     = 11;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;

  localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(WINDOW_MAX);
  localparam logic [CNT_W-1:0] LEN_MIN = CNT_W'(1);

  typedef struct packed {
    logic                   en;
    logic [PTR_W-1:0]       addr;
    logic [SAMPLE_BITS-1:0] data;
  } mem_wr_t;

  function automatic logic [CNT_W-1:0] sat_len(input logic [LEN_W-1:0] raw);
    logic [CNT_W-1:0] v;
    v = CNT_W'(raw);
    if (v == '0) begin
      return LEN_MIN;
    end else if (v > LEN_MAX) begin
      return LEN_MAX;
    end
    return v;
  endfunction

endpackage

FILE: rtl/rwwm_delay.sv
module rwwm_delay (
  input  logic                                clk_i,
  input  rwwm_pkg::mem_wr_t                   wr_i,
  input  logic [rwwm_pkg::PTR_W-1:0]          rd_addr_i,
  output logic [rwwm_pkg::SAMPLE_BITS-1:0]    rd_data_o
);

  logic [rwwm_pkg::SAMPLE_BITS-1:0] mem [rwwm_pkg::WINDOW_MAX];
  logic [rwwm_pkg::SAMPLE_BITS-1:0] rd_q;
  logic [rwwm_pkg::SAMPLE_BITS-1:0] byp_data_q;
  logic                             byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q       <= mem[rd_addr_i];
    byp_q      <= wr_i.en && (wr_i.addr == rd_addr_i);
    byp_data_q <= wr_i.data;
  end

  // forward a write that lands on the address being read in the same cycle
  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

FILE: rtl/ramp_weighted_window_max.sv
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  sample_i, restart_i
// output    out        out_valid_o / out_stall_i weighted_sum_o, best_sum_o, window_full_o
// config    in         psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// One transfer per cycle unless the output stalls; a result passes the input register, then the output register.
// The sum, weight and maximum recurrence is updated from the state registers through a 32x12 multiply.
// Reset clears the sums, count, pointer and maximum; window_len returns to 1.
// A stalled result holds in the output register; the input register stalls behind it.
// The delay line read is prefetched from the next pointer, with write forwarding.
module ramp_weighted_window_max (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [rwwm_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                                     restart_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [rwwm_pkg::SUM_W-1:0]        weighted_sum_o,
  output logic signed [rwwm_pkg::SUM_W-1:0]        best_sum_o,
  output logic                                     window_full_o,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [rwwm_pkg::PADDR_W-1:0]             paddr,
  input  logic [rwwm_pkg::DATA_W-1:0]              pwdata,
  output logic [rwwm_pkg::DATA_W-1:0]              prdata,
  output logic                                     pready
);

  localparam int unsigned PW = rwwm_pkg::PTR_W;
  localparam int unsigned CW = rwwm_pkg::CNT_W;
  localparam int unsigned SW = rwwm_pkg::SUM_W;
  localparam int unsigned WW = rwwm_pkg::WSUM_W;
  localparam int unsigned XW = rwwm_pkg::PROD_W;
  localparam int unsigned DW = rwwm_pkg::SAMPLE_BITS;

  logic [rwwm_pkg::LEN_W-1:0] window_len_q;
  logic [CW-1:0]              m_q;
  logic                       cfg_wr;
  logic [rwwm_pkg::REG_IDX_W-1:0] reg_idx;

  logic                 v1_q;
  logic signed [DW-1:0] smp_q;
  logic                 rst_smp_q;
  logic                 adv;

  logic [PW-1:0]        ptr_q, ptr_d, ptr_base, ptr_next;
  logic [CW-1:0]        ptr_inc;
  logic [CW-1:0]        cnt_q, cnt_d, cnt_base, cnt_new, k;
  logic signed [WW-1:0] wsum_q, wsum_d, wsum_base, wsum_new;
  logic signed [SW-1:0] ramp_q, ramp_d, ramp_base, ramp_new;
  logic signed [SW-1:0] best_q, best_d, best_base, best_new;
  logic signed [XW-1:0] prod;
  logic signed [DW-1:0] leave;
  logic                 full_in, full_out;

  logic                 out_valid_q;
  logic signed [SW-1:0] wsum_out_q, best_out_q;
  logic                 full_out_q;

  rwwm_pkg::mem_wr_t    mem_wr;

  assign reg_idx = paddr[rwwm_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == rwwm_pkg::REG_WINDOW_LEN);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == rwwm_pkg::REG_WINDOW_LEN)
                 ? rwwm_pkg::DATA_W'(window_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= rwwm_pkg::LEN_W'(1);
      m_q          <= rwwm_pkg::LEN_MIN;
    end else if (cfg_wr) begin
      window_len_q <= pwdata[rwwm_pkg::LEN_W-1:0];
      m_q          <= rwwm_pkg::sat_len(pwdata[rwwm_pkg::LEN_W-1:0]);
    end
  end

  assign adv        = v1_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = v1_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (!in_stall_o) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      smp_q     <= sample_i;
      rst_smp_q <= restart_i;
    end
  end

  // apply restart before the sample
  assign ptr_base  = rst_smp_q ? '0 : ptr_q;
  assign cnt_base  = rst_smp_q ? '0 : cnt_q;
  assign wsum_base = rst_smp_q ? '0 : wsum_q;
  assign ramp_base = rst_smp_q ? '0 : ramp_q;
  assign best_base = rst_smp_q ? '0 : best_q;

  assign full_in = (cnt_base == m_q);
  assign k       = full_in ? m_q : cnt_base + CW'(1);
  assign prod    = smp_q * $signed({1'b0, k});

  assign ramp_new = ramp_base + {{(SW-XW){prod[XW-1]}}, prod}
                  - (full_in ? {{(SW-WW){wsum_base[WW-1]}}, wsum_base} : SW'(0));
  assign wsum_new = wsum_base + {{(WW-DW){smp_q[DW-1]}}, smp_q}
                  - (full_in ? {{(WW-DW){leave[DW-1]}}, leave} : WW'(0));
  assign cnt_new  = full_in ? cnt_base : cnt_base + CW'(1);
  assign full_out = (cnt_new == m_q);

  always_comb begin
    if (full_in) begin
      best_new = (ramp_new > best_base) ? ramp_new : best_base;
    end else if (full_out) begin
      best_new = ramp_new;
    end else begin
      best_new = best_base;
    end
  end

  assign ptr_inc  = {1'b0, ptr_base} + CW'(1);
  assign ptr_next = (ptr_inc >= m_q) ? '0 : ptr_inc[PW-1:0];

  always_comb begin
    ptr_d  = ptr_q;
    cnt_d  = cnt_q;
    wsum_d = wsum_q;
    ramp_d = ramp_q;
    best_d = best_q;
    if (cfg_wr) begin
      ptr_d  = '0;
      cnt_d  = '0;
      wsum_d = '0;
      ramp_d = '0;
      best_d = '0;
    end else if (adv) begin
      ptr_d  = ptr_next;
      cnt_d  = cnt_new;
      wsum_d = wsum_new;
      ramp_d = ramp_new;
      best_d = best_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      cnt_q  <= '0;
      wsum_q <= '0;
      ramp_q <= '0;
      best_q <= '0;
    end else begin
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
      wsum_q <= wsum_d;
      ramp_q <= ramp_d;
      best_q <= best_d;
    end
  end

  assign mem_wr.en   = adv;
  assign mem_wr.addr = ptr_base;
  assign mem_wr.data = smp_q;

  rwwm_delay u_delay (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_addr_i (ptr_d),
    .rd_data_o (leave)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wsum_out_q <= ramp_new;
      best_out_q <= full_out ? best_new : '0;
      full_out_q <= full_out;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign weighted_sum_o = wsum_out_q;
  assign best_sum_o     = best_out_q;
  assign window_full_o  = full_out_q;

endmodule

FILE: rtl/rwwm_checker.sv
module rwwm_checker (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     in_valid_i,
  input logic                                     in_stall_o,
  input logic                                     out_valid_o,
  input logic                                     out_stall_i,
  input logic signed [rwwm_pkg::SUM_W-1:0]        weighted_sum_o,
  input logic signed [rwwm_pkg::SUM_W-1:0]        best_sum_o,
  input logic                                     window_full_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(weighted_sum_o)
      && $stable(best_sum_o) && $stable(window_full_o))
    else $error("stalled result changed");

  a_best_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_full_o |-> best_sum_o == '0)
    else $error("best_sum nonzero before window full");

  a_best_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_full_o |-> weighted_sum_o <= best_sum_o)
    else $error("weighted_sum above best_sum");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching input transfer");

endmodule

bind ramp_weighted_window_max rwwm_checker u_checker (.*);

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_BITS = rwwm_pkg::SAMPLE_BITS;
  localparam int unsigned SUM_W       = rwwm_pkg::SUM_W;
  localparam int unsigned PADDR_W     = rwwm_pkg::PADDR_W;
  localparam int unsigned DATA_W      = rwwm_pkg::DATA_W;
  localparam int unsigned WINDOW_MAX  = rwwm_pkg::WINDOW_MAX;
  localparam int unsigned LEN_W       = rwwm_pkg::LEN_W;
  localparam int unsigned PTR_W       = rwwm_pkg::PTR_W;

  localparam logic [PADDR_W-1:0] LEN_ADDR = PADDR_W'(4 * rwwm_pkg::REG_WINDOW_LEN);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } sample_item_t;

  typedef struct {
    logic signed [SUM_W-1:0] weighted;
    logic signed [SUM_W-1:0] best;
    logic                    full;
  } ramp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                          restart_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SUM_W-1:0]       weighted_sum_o;
  logic signed [SUM_W-1:0]       best_sum_o;
  logic                          window_full_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [PADDR_W-1:0]            paddr = '0;
  logic [DATA_W-1:0]             pwdata = '0;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;

  sample_item_t pending_samples[$];
  ramp_result_t ramp_expect_q[$];

  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  int unsigned in_pace = 0;
  int unsigned out_pace = 0;
  int unsigned phase_no = 0;
  int unsigned mismatches = 0;

  // Predictor state
  logic signed [SAMPLE_BITS-1:0] tap_mem [WINDOW_MAX];
  logic [LEN_W-1:0]              len_reg = LEN_W'(1);
  int unsigned                   tap_ptr = 0;
  int unsigned                   tap_count = 0;
  longint                        win_acc = 0;
  longint                        ramp_acc = 0;
  longint                        peak_acc = 0;

  ramp_weighted_window_max DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .weighted_sum_o(weighted_sum_o),
    .best_sum_o    (best_sum_o),
    .window_full_o (window_full_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void ramp_clear();
    tap_ptr = 0;
    tap_count = 0;
    win_acc = 0;
    ramp_acc = 0;
    peak_acc = 0;
  endfunction

  function automatic ramp_result_t ramp_predict(input logic signed [SAMPLE_BITS-1:0] s,
                                                input logic clr);
    ramp_result_t r;
    int unsigned  m;
    longint       leaving;
    if (len_reg == '0) begin
      m = 1;
    end else if (len_reg > WINDOW_MAX) begin
      m = WINDOW_MAX;
    end else begin
      m = 32'(len_reg);
    end
    if (clr) begin
      ramp_clear();
    end
    if (tap_ptr >= m) begin
      tap_ptr = 0;
    end
    if (tap_count < m) begin
      tap_count++;
      ramp_acc += longint'(s) * longint'(tap_count);
      win_acc += longint'(s);
      tap_mem[PTR_W'(tap_ptr)] = s;
      if (tap_count == m) begin
        peak_acc = ramp_acc;
      end
    end else begin
      leaving = longint'(tap_mem[PTR_W'(tap_ptr)]);
      ramp_acc = ramp_acc - win_acc + longint'(s) * longint'(m);
      win_acc = win_acc + longint'(s) - leaving;
      tap_mem[PTR_W'(tap_ptr)] = s;
      if (ramp_acc > peak_acc) begin
        peak_acc = ramp_acc;
      end
    end
    tap_ptr++;
    if (tap_ptr >= m) begin
      tap_ptr = 0;
    end
    r.full = (tap_count >= m);
    r.weighted = ramp_acc[SUM_W-1:0];
    r.best = r.full ? peak_acc[SUM_W-1:0] : '0;
    return r;
  endfunction

  function automatic int unsigned draw_wait(input int unsigned mode);
    case (mode)
      0: begin
        return 0;
      end
      1: begin
        return $urandom_range(0, 13);
      end
      default: begin
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
      end
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int unsigned style);
    if (style == 1) begin
      return ($urandom_range(0, 9) < 7) ? SAMPLE_HI : SAMPLE_BITS'($urandom);
    end
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_HI;
          1: return SAMPLE_LO;
          2: return '0;
          3: return '1;
          default: return SAMPLE_BITS'(1);
        endcase
      end
      1: begin
        return SAMPLE_BITS'(int'($urandom_range(0, 400)) - 200);
      end
      default: begin
        return SAMPLE_BITS'($urandom);
      end
    endcase
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic clr);
    sample_item_t it;
    it.sample = s;
    it.restart = clr;
    pending_samples.push_back(it);
  endtask

  task automatic reg_write(input int unsigned value);
    logic [LEN_W-1:0] raw;
    raw = LEN_W'(value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LEN_ADDR;
    pwdata <= DATA_W'(raw);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    len_reg = raw;
    ramp_clear();
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DATA_W'(raw)) begin
      flag_mismatch($sformatf("window_len read %h, wrote %h", prdata, raw));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while ((pending_samples.size() != 0 || in_valid_i || ramp_expect_q.size() != 0)
               && guard < 100000);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_pace();
    in_pace = phase_no % 3;
    out_pace = (phase_no / 3) % 3;
    phase_no++;
  endtask

  task automatic run_random_phase(input int unsigned len, input int unsigned count,
                                  input int unsigned style, input int unsigned restart_odds);
    logic signed [SAMPLE_BITS-1:0] s;
    logic                          clr;
    reg_write(len);
    @(negedge clk_i);
    set_pace();
    for (int unsigned i = 0; i < count; i++) begin
      s = pick_sample(style);
      if (style == 1 && i + 16 >= count) begin
        s = SAMPLE_LO;
      end
      clr = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
      push_sample(s, clr);
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    sample_item_t next_item;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_samples.size() != 0) begin
        next_item = pending_samples.pop_front();
        in_valid_i <= 1'b1;
        sample_i <= next_item.sample;
        restart_i <= next_item.restart;
        in_gap <= draw_wait(in_pace);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    int unsigned hold_next;
    if (rst_ni) begin
      if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_stall_i <= (out_hold != 1);
      end else if (out_valid_o && !out_stall_i) begin
        hold_next = draw_wait(out_pace);
        out_hold <= hold_next;
        out_stall_i <= (hold_next != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    ramp_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (ramp_expect_q.size() == 0) begin
          flag_mismatch("result transfer with nothing expected");
        end else begin
          want = ramp_expect_q.pop_front();
          if (weighted_sum_o !== want.weighted) begin
            flag_mismatch($sformatf("weighted_sum %h, expected %h",
                                    weighted_sum_o, want.weighted));
          end
          if (best_sum_o !== want.best) begin
            flag_mismatch($sformatf("best_sum %h, expected %h", best_sum_o, want.best));
          end
          if (window_full_o !== want.full) begin
            flag_mismatch($sformatf("window_full %b, expected %b",
                                    window_full_o, want.full));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        ramp_expect_q.push_back(ramp_predict(sample_i, restart_i));
      end
    end
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset window length of one
    set_pace();
    push_sample(SAMPLE_HI, 1'b1);
    push_sample(SAMPLE_LO, 1'b0);
    push_sample('0, 1'b0);
    push_sample('1, 1'b0);
    push_sample(SAMPLE_BITS'(1), 1'b0);
    push_sample(SAMPLE_BITS'(32'h5555_5555), 1'b1);
    push_sample(SAMPLE_BITS'(32'haaaa_aaaa), 1'b0);
    wait_drained();

    // Fill, slide, restart while full
    reg_write(3);
    @(negedge clk_i);
    set_pace();
    push_sample(SAMPLE_HI, 1'b0);
    push_sample(SAMPLE_HI, 1'b0);
    push_sample(SAMPLE_HI, 1'b0);
    push_sample(SAMPLE_LO, 1'b0);
    push_sample(SAMPLE_LO, 1'b0);
    push_sample('1, 1'b0);
    push_sample(SAMPLE_BITS'(5), 1'b1);
    push_sample(SAMPLE_BITS'(6), 1'b0);
    push_sample(SAMPLE_BITS'(7), 1'b0);
    push_sample(SAMPLE_BITS'(8), 1'b0);
    push_sample(SAMPLE_BITS'(-9), 1'b1);
    push_sample('0, 1'b0);
    wait_drained();

    run_random_phase(0, 50, 0, 25);
    run_random_phase(2, 60, 0, 25);
    run_random_phase(WINDOW_MAX + 1, 1040, 1, 0);
    run_random_phase(2047, 30, 0, 25);
    run_random_phase(WINDOW_MAX, 30, 0, 25);
    repeat (5) run_random_phase($urandom_range(1, 16), 60, 0, 25);
    run_random_phase(64, 200, 0, 150);

    if (ramp_expect_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", ramp_expect_q.size()));
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: ramp_weighted_window_max.f
rtl/rwwm_pkg.sv
rtl/rwwm_delay.sv
rtl/ramp_weighted_window_max.sv
rtl/rwwm_checker.sv
bench/tb.sv
